@@ rtl/ffc_pkg.sv @@
// shared constants, codes and types for the feature filter correlation block
package ffc_pkg;

  localparam int MAX_MAP_ROWS    = 64;
  localparam int MAX_MAP_COLS    = 64;
  localparam int MAX_CHANNELS    = 32;
  localparam int MAX_FILTER_ROWS = 16;
  localparam int MAX_FILTER_COLS = 16;
  localparam int NUM_FILTERS     = 6;

  localparam int SAMPLE_W = 16;
  localparam int PROD_W   = 2 * SAMPLE_W;
  localparam int RESP_W   = 48;

  localparam int FEAT_DEPTH = MAX_CHANNELS * MAX_MAP_ROWS * MAX_MAP_COLS;
  localparam int FEAT_AW    = $clog2(FEAT_DEPTH);
  localparam int WGT_DEPTH  = NUM_FILTERS * MAX_CHANNELS * MAX_FILTER_ROWS * MAX_FILTER_COLS;
  localparam int WGT_AW     = $clog2(WGT_DEPTH);

  // commands
  localparam logic [1:0] CMD_WR_WEIGHT  = 2'd0;
  localparam logic [1:0] CMD_WR_FEATURE = 2'd1;
  localparam logic [1:0] CMD_COMPUTE    = 2'd2;

  // configuration register indexes
  localparam logic [2:0] REG_MAP_ROWS    = 3'd0;
  localparam logic [2:0] REG_MAP_COLS    = 3'd1;
  localparam logic [2:0] REG_NUM_CHANNELS = 3'd2;
  localparam logic [2:0] REG_FILTER_ROWS = 3'd3;
  localparam logic [2:0] REG_FILTER_COLS = 3'd4;

  // sizes in use, as seen by the sequencer
  typedef struct packed {
    logic [5:0] nch;
    logic [4:0] frows;
    logic [4:0] fcols;
  } ffc_size_t;

  // compute job handed to the sequencer
  typedef struct packed {
    logic [2:0] fsel;
    logic [5:0] row;
    logic [5:0] col;
  } ffc_job_t;

  // tag of one memory read issued by the sequencer
  typedef struct packed {
    logic vld;
    logic first;
    logic last;
  } ffc_issue_t;

endpackage

@@ rtl/ffc_feat_store.sv @@
// feature map memory: one write port, one registered read port
module ffc_feat_store import ffc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [FEAT_AW-1:0]         waddr_i,
  input  logic signed [SAMPLE_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [FEAT_AW-1:0]         raddr_i,
  output logic signed [SAMPLE_W-1:0] rdata_o
);

  logic signed [SAMPLE_W-1:0] mem_q [FEAT_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ffc_wgt_store.sv @@
// filter weight memory: one write port, one registered read port
module ffc_wgt_store import ffc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       we_i,
  input  logic [WGT_AW-1:0]          waddr_i,
  input  logic signed [SAMPLE_W-1:0] wdata_i,
  input  logic                       re_i,
  input  logic [WGT_AW-1:0]          raddr_i,
  output logic signed [SAMPLE_W-1:0] rdata_o
);

  logic signed [SAMPLE_W-1:0] mem_q [WGT_DEPTH];
  logic signed [SAMPLE_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ffc_seq.sv @@
// read sequencer: walks channels, filter rows and filter columns of one job
module ffc_seq import ffc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               launch_i,
  input  ffc_job_t           job_i,
  input  ffc_size_t          size_i,
  output logic [FEAT_AW-1:0] feat_raddr_o,
  output logic [WGT_AW-1:0]  wgt_raddr_o,
  output ffc_issue_t         issue_o
);

  logic       run_q, run_d;
  logic [2:0] fsel_q, fsel_d;
  logic [5:0] row_q, row_d;
  logic [5:0] col_q, col_d;
  logic [4:0] k_q, k_d;
  logic [3:0] fr_q, fr_d;
  logic [3:0] fc_q, fc_d;

  logic [4:0] nch_m1;
  logic [3:0] frows_m1;
  logic [3:0] fcols_m1;
  logic       k_end, fr_end, fc_end, last;
  logic [5:0] frow_abs, fcol_abs;

  assign nch_m1   = 5'(size_i.nch - 6'd1);
  assign frows_m1 = 4'(size_i.frows - 5'd1);
  assign fcols_m1 = 4'(size_i.fcols - 5'd1);

  assign k_end  = (k_q == nch_m1);
  assign fr_end = (fr_q == frows_m1);
  assign fc_end = (fc_q == fcols_m1);
  assign last   = k_end && fr_end && fc_end;

  // the job was checked on entry, so these sums stay inside the map
  assign frow_abs = row_q + {2'b00, fr_q};
  assign fcol_abs = col_q + {2'b00, fc_q};

  assign feat_raddr_o = {k_q, frow_abs, fcol_abs};
  assign wgt_raddr_o  = {fsel_q, k_q, fr_q, fc_q};

  assign issue_o.vld   = run_q;
  assign issue_o.first = (k_q == 5'd0) && (fr_q == 4'd0) && (fc_q == 4'd0);
  assign issue_o.last  = last;

  always_comb begin
    run_d  = run_q;
    fsel_d = fsel_q;
    row_d  = row_q;
    col_d  = col_q;
    k_d    = k_q;
    fr_d   = fr_q;
    fc_d   = fc_q;
    if (launch_i) begin
      run_d  = 1'b1;
      fsel_d = job_i.fsel;
      row_d  = job_i.row;
      col_d  = job_i.col;
      k_d    = '0;
      fr_d   = '0;
      fc_d   = '0;
    end else if (run_q) begin
      if (last) begin
        run_d = 1'b0;
      end
      if (fc_end) begin
        fc_d = '0;
        if (fr_end) begin
          fr_d = '0;
          k_d  = k_q + 5'd1;
        end else begin
          fr_d = fr_q + 4'd1;
        end
      end else begin
        fc_d = fc_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      k_q   <= '0;
      fr_q  <= '0;
      fc_q  <= '0;
    end else begin
      run_q <= run_d;
      k_q   <= k_d;
      fr_q  <= fr_d;
      fc_q  <= fc_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fsel_q <= fsel_d;
    row_q  <= row_d;
    col_q  <= col_d;
  end

endmodule

@@ rtl/ffc_mac.sv @@
// multiply-accumulate pipeline: align with read data, multiply, accumulate
module ffc_mac import ffc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  ffc_issue_t                 issue_i,
  input  logic signed [SAMPLE_W-1:0] feat_i,
  input  logic signed [SAMPLE_W-1:0] wgt_i,
  output logic signed [RESP_W-1:0]   resp_o,
  output logic                       done_o
);

  ffc_issue_t                 rd_q;
  ffc_issue_t                 prod_tag_q;
  logic signed [PROD_W-1:0]   prod_q;
  logic signed [RESP_W-1:0]   acc_q, acc_d;
  logic signed [RESP_W-1:0]   prod_ext;
  logic                       done_q;

  assign prod_ext = {{(RESP_W-PROD_W){prod_q[PROD_W-1]}}, prod_q};
  assign acc_d    = prod_tag_q.first ? prod_ext : acc_q + prod_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q       <= '0;
      prod_tag_q <= '0;
      done_q     <= 1'b0;
    end else begin
      rd_q       <= issue_i;
      prod_tag_q <= rd_q;
      done_q     <= prod_tag_q.vld && prod_tag_q.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_q.vld) begin
      prod_q <= PROD_W'(feat_i) * PROD_W'(wgt_i);
    end
    if (prod_tag_q.vld) begin
      acc_q <= acc_d;
    end
  end

  assign resp_o = acc_q;
  assign done_o = done_q;

endmodule

@@ rtl/feature_filter_correlation.sv @@
// top level: command decode, configuration registers, stores and result port
// results: a write gives no result; a failing compute gives its result in the cycle
// after start; a valid compute reads N = num_channels*filter_rows*filter_cols pairs,
// one product per cycle from the two stores, and gives its sum after the last one
// for a valid compute, busy is high from the cycle after start until the result cycle,
// and no next start is taken while busy; results cannot be held off by the receiver
// reset clears the configuration to its maxima; store contents are undefined until written
module feature_filter_correlation import ffc_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command_i,
  input  logic [2:0]                 filter_select_i,
  input  logic [5:0]                 row_i,
  input  logic [5:0]                 col_i,
  input  logic [4:0]                 channel_i,
  input  logic signed [SAMPLE_W-1:0] sample_i,
  output logic                       done_o,
  output logic signed [RESP_W-1:0]   response_o,
  output logic                       error_o,
  input  logic                       cfg_valid_i,
  output logic                       cfg_ready_o,
  input  logic [2:0]                 cfg_index_i,
  input  logic [6:0]                 cfg_data_i
);

  function automatic logic [6:0] clamp_val(input logic [6:0] v, input logic [6:0] hi);
    logic [6:0] r;
    if (v == 7'd0) begin
      r = 7'd1;
    end else if (v > hi) begin
      r = hi;
    end else begin
      r = v;
    end
    return r;
  endfunction

  logic [6:0] map_rows_q, map_cols_q;
  logic [5:0] num_channels_q;
  logic [4:0] filter_rows_q, filter_cols_q;
  logic       busy_q, busy_d;
  logic       err_done_q;

  logic       accept, cfg_we;
  logic       cmp_cmd, cmp_bad, launch;
  logic       feat_we, wgt_we;
  logic [6:0] fr_ext, fc_ext, row_lim, col_lim;

  logic [FEAT_AW-1:0]         feat_waddr, feat_raddr;
  logic [WGT_AW-1:0]          wgt_waddr, wgt_raddr;
  logic signed [SAMPLE_W-1:0] feat_rdata, wgt_rdata;
  ffc_issue_t                 issue;
  ffc_job_t                   job;
  ffc_size_t                  size;
  logic signed [RESP_W-1:0]   mac_resp;
  logic                       mac_done;

  assign cfg_ready_o = 1'b1;
  assign cfg_we      = cfg_valid_i && cfg_ready_o;
  assign busy        = busy_q;
  assign accept      = start && !busy_q;

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      map_rows_q     <= 7'(MAX_MAP_ROWS);
      map_cols_q     <= 7'(MAX_MAP_COLS);
      num_channels_q <= 6'(MAX_CHANNELS);
      filter_rows_q  <= 5'(MAX_FILTER_ROWS);
      filter_cols_q  <= 5'(MAX_FILTER_COLS);
    end else if (cfg_we) begin
      unique case (cfg_index_i)
        REG_MAP_ROWS: begin
          map_rows_q <= clamp_val(cfg_data_i, 7'(MAX_MAP_ROWS));
        end
        REG_MAP_COLS: begin
          map_cols_q <= clamp_val(cfg_data_i, 7'(MAX_MAP_COLS));
        end
        REG_NUM_CHANNELS: begin
          num_channels_q <= 6'(clamp_val({1'b0, cfg_data_i[5:0]}, 7'(MAX_CHANNELS)));
        end
        REG_FILTER_ROWS: begin
          filter_rows_q <= 5'(clamp_val({2'b00, cfg_data_i[4:0]}, 7'(MAX_FILTER_ROWS)));
        end
        REG_FILTER_COLS: begin
          filter_cols_q <= 5'(clamp_val({2'b00, cfg_data_i[4:0]}, 7'(MAX_FILTER_COLS)));
        end
        default: begin
        end
      endcase
    end
  end

  // store writes
  assign feat_we    = accept && (command_i == CMD_WR_FEATURE);
  assign wgt_we     = accept && (command_i == CMD_WR_WEIGHT)
                      && (filter_select_i < 3'(NUM_FILTERS))
                      && (row_i < 6'(MAX_FILTER_ROWS))
                      && (col_i < 6'(MAX_FILTER_COLS));
  assign feat_waddr = {channel_i, row_i, col_i};
  assign wgt_waddr  = {filter_select_i, channel_i, row_i[3:0], col_i[3:0]};

  // compute entry check
  assign fr_ext  = {2'b00, filter_rows_q};
  assign fc_ext  = {2'b00, filter_cols_q};
  assign row_lim = map_rows_q - fr_ext;
  assign col_lim = map_cols_q - fc_ext;
  assign cmp_cmd = accept && (command_i == CMD_COMPUTE);
  assign cmp_bad = (filter_select_i >= 3'(NUM_FILTERS))
                   || (fr_ext > map_rows_q) || (fc_ext > map_cols_q)
                   || ({1'b0, row_i} > row_lim) || ({1'b0, col_i} > col_lim);
  assign launch  = cmp_cmd && !cmp_bad;

  assign job.fsel   = filter_select_i;
  assign job.row    = row_i;
  assign job.col    = col_i;
  assign size.nch   = num_channels_q;
  assign size.frows = filter_rows_q;
  assign size.fcols = filter_cols_q;

  assign busy_d = launch ? 1'b1 : (mac_done ? 1'b0 : busy_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q     <= 1'b0;
      err_done_q <= 1'b0;
    end else begin
      busy_q     <= busy_d;
      err_done_q <= cmp_cmd && cmp_bad;
    end
  end

  ffc_seq u_seq (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .launch_i     (launch),
    .job_i        (job),
    .size_i       (size),
    .feat_raddr_o (feat_raddr),
    .wgt_raddr_o  (wgt_raddr),
    .issue_o      (issue)
  );

  ffc_feat_store u_feat_store (
    .clk_i   (clk_i),
    .we_i    (feat_we),
    .waddr_i (feat_waddr),
    .wdata_i (sample_i),
    .re_i    (issue.vld),
    .raddr_i (feat_raddr),
    .rdata_o (feat_rdata)
  );

  ffc_wgt_store u_wgt_store (
    .clk_i   (clk_i),
    .we_i    (wgt_we),
    .waddr_i (wgt_waddr),
    .wdata_i (sample_i),
    .re_i    (issue.vld),
    .raddr_i (wgt_raddr),
    .rdata_o (wgt_rdata)
  );

  ffc_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .feat_i  (feat_rdata),
    .wgt_i   (wgt_rdata),
    .resp_o  (mac_resp),
    .done_o  (mac_done)
  );

  // error beats and sum beats never share a cycle: the sum only ends while busy
  assign done_o     = err_done_q || mac_done;
  assign error_o    = err_done_q;
  assign response_o = err_done_q ? '0 : mac_resp;

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    error_o |-> (done_o && (response_o == '0)))
    else $error("error beat with non-zero response");

  a_sum_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |-> (busy_q && !err_done_q))
    else $error("sum beat outside a running compute");

  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(busy_q) |-> !mac_done)
    else $error("sum beat in the first busy cycle");

  a_busy_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mac_done |=> !busy_q)
    else $error("busy held after the sum beat");

endmodule
